@@ design/mse_pkg.sv @@
`timescale 1ns / 1ps

package mse_pkg;

    // Datapath and field widths.
    localparam int XLEN        = 32;
    localparam int REG_COUNT   = 32;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int STATUS_W    = 2;
    localparam int MEM_INDEX_W = 10;

    // Data memory geometry.
    localparam int DATA_WORDS = 1024;
    localparam int DMEM_AW    = $clog2(DATA_WORDS);
    localparam int WORD_IDX_W = XLEN - 2;

    // Configuration port geometry.
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int CFG_IDX_W      = PADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_START = '0;

    // Program counter value after reset.
    localparam logic [XLEN-1:0] START_RESET = 32'h0040_0000;

    // Opcode and function codes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] FUNCT_SUBU = 6'h23;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_OP   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_HALTED   = 2'd3;

    // One register file write, as carried to the bypass and the array.
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] idx;
        logic [XLEN-1:0]      data;
    } rf_write_t;

endpackage

@@ design/mse_if.sv @@
`timescale 1ns / 1ps

// Instruction channel.
interface mse_in_if;
    import mse_pkg::*;

    logic            valid;
    logic            ready;
    logic [XLEN-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink (input valid, input instruction, output ready);
endinterface

// Result channel.
interface mse_out_if;
    import mse_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [XLEN-1:0]        next_pc;
    logic [STATUS_W-1:0]    status;
    logic                   reg_written;
    logic [REG_IDX_W-1:0]   reg_index;
    logic [XLEN-1:0]        reg_value;
    logic                   mem_written;
    logic [MEM_INDEX_W-1:0] mem_index;
    logic [XLEN-1:0]        mem_value;

    modport source (
        output valid, output next_pc, output status, output reg_written,
        output reg_index, output reg_value, output mem_written,
        output mem_index, output mem_value, input ready
    );
    modport sink (
        input valid, input next_pc, input status, input reg_written,
        input reg_index, input reg_value, input mem_written,
        input mem_index, input mem_value, output ready
    );
endinterface

@@ design/mse_regfile.sv @@
`timescale 1ns / 1ps

module mse_regfile (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [mse_pkg::REG_IDX_W-1:0] rd_addr_a,
    input  logic [mse_pkg::REG_IDX_W-1:0] rd_addr_b,
    output logic [mse_pkg::XLEN-1:0]      rd_data_a,
    output logic [mse_pkg::XLEN-1:0]      rd_data_b,
    input  mse_pkg::rf_write_t            wr
);
    import mse_pkg::*;

    logic [XLEN-1:0]      mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [XLEN-1:0]      data_a_reg;
    logic [XLEN-1:0]      data_b_reg;
    logic                 valid_a_reg;
    logic                 valid_b_reg;

    // Array write and registered reads on two ports.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[rd_addr_a];
            data_b_reg <= mem[rd_addr_b];
        end
    end

    // Written flags: an entry never written reads as zero. Entry zero is
    // never written, so register zero always reads zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                valid_a_reg <= valid_reg[rd_addr_a];
                valid_b_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = valid_a_reg ? data_a_reg : '0;
    assign rd_data_b = valid_b_reg ? data_b_reg : '0;

endmodule

@@ design/mse_dmem.sv @@
`timescale 1ns / 1ps

module mse_dmem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [mse_pkg::DMEM_AW-1:0] wr_addr,
    input  logic [mse_pkg::XLEN-1:0]    wr_data,
    output logic                        busy
);
    import mse_pkg::*;

    logic [XLEN-1:0]    mem [DATA_WORDS];
    logic               clearing_reg;
    logic [DMEM_AW-1:0] clr_addr_reg;
    logic               we;
    logic [DMEM_AW-1:0] waddr;
    logic [XLEN-1:0]    wdata;

    // The clearing sweep owns the write port until it finishes.
    always_comb
    begin
        we    = clearing_reg | wr_en;
        waddr = clearing_reg ? clr_addr_reg : wr_addr;
        wdata = clearing_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Sweep counter, one word per cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == DMEM_AW'(DATA_WORDS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + DMEM_AW'(1);
        end
    end

    assign busy = clearing_reg;

endmodule

@@ design/mips_subset_executor.sv @@
`timescale 1ns / 1ps

// Channel    Direction  Payload
// inst_in    sink       instruction
// res_out    source     next_pc, status, reg_written, reg_index, reg_value,
//                       mem_written, mem_index, mem_value
// APB        slave      start_address at byte offset 0
//
// One instruction per cycle sustained while the result channel is ready. The
// register file read is registered at the edge that takes the item, execute
// and write back follow, and the result is registered as execute advances.
// A write in the execute cycle is forwarded to the instruction behind it.
// After reset the data memory is cleared word by word, and no item is taken
// while it is cleared. A stalled result register holds the execute stage, which
// in turn holds the input.

module mips_subset_executor (
    input  logic                        clk,
    input  logic                        rst_n,
    mse_in_if.sink                      inst_in,
    mse_out_if.source                   res_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mse_pkg::PADDR_W-1:0] paddr,
    input  logic [mse_pkg::PDATA_W-1:0] pwdata,
    output logic [mse_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import mse_pkg::*;

    logic                   dmem_busy;
    logic                   accept;
    logic                   ex_advance;
    logic                   cfg_write;

    logic [XLEN-1:0]        start_address_reg;
    logic [XLEN-1:0]        pc_reg;
    logic                   halted_reg;
    logic                   ex_valid_reg;
    logic [XLEN-1:0]        ex_inst_reg;
    rf_write_t              byp_reg;

    logic [XLEN-1:0]        rf_a;
    logic [XLEN-1:0]        rf_b;
    rf_write_t              rf_wr;

    logic [5:0]             op;
    logic [5:0]             funct;
    logic [REG_IDX_W-1:0]   rs;
    logic [REG_IDX_W-1:0]   rt;
    logic [REG_IDX_W-1:0]   rd;
    logic [XLEN-1:0]        imm;
    logic [XLEN-1:0]        rs_val;
    logic [XLEN-1:0]        rt_val;
    logic [XLEN-1:0]        sum;
    logic [XLEN-1:0]        seq_pc;
    logic [WORD_IDX_W-1:0]  word;

    logic [XLEN-1:0]        next_pc_next;
    logic [STATUS_W-1:0]    status_next;
    logic                   rw_next;
    logic [REG_IDX_W-1:0]   ridx_next;
    logic [XLEN-1:0]        rval_next;
    logic                   mw_next;
    logic [MEM_INDEX_W-1:0] midx_next;
    logic [XLEN-1:0]        mval_next;

    logic                   out_valid_reg;
    logic [XLEN-1:0]        next_pc_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic                   reg_written_reg;
    logic [REG_IDX_W-1:0]   reg_index_reg;
    logic [XLEN-1:0]        reg_value_reg;
    logic                   mem_written_reg;
    logic [MEM_INDEX_W-1:0] mem_index_reg;
    logic [XLEN-1:0]        mem_value_reg;

    // Handshake and stage control.
    assign ex_advance    = ex_valid_reg && (!out_valid_reg || res_out.ready);
    assign inst_in.ready = !dmem_busy && (!ex_valid_reg || ex_advance);
    assign accept        = inst_in.valid && inst_in.ready;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1:2] == CFG_IDX_START);
    assign prdata    = (paddr[PADDR_W-1:2] == CFG_IDX_START) ? start_address_reg : '0;

    // Register file, read as the item is taken.
    mse_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (inst_in.instruction[25:21]),
        .rd_addr_b (inst_in.instruction[20:16]),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b),
        .wr        (rf_wr)
    );

    // Data memory, written by stores.
    mse_dmem u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ex_advance && mw_next),
        .wr_addr (word[DMEM_AW-1:0]),
        .wr_data (mval_next),
        .busy    (dmem_busy)
    );

    // Decode fields of the instruction in the execute stage.
    always_comb
    begin
        op    = ex_inst_reg[31:26];
        rs    = ex_inst_reg[25:21];
        rt    = ex_inst_reg[20:16];
        rd    = ex_inst_reg[15:11];
        funct = ex_inst_reg[5:0];
        imm   = {{(XLEN - 16){ex_inst_reg[15]}}, ex_inst_reg[15:0]};
    end

    // Forward the previous write, which may land at the same edge as this read.
    always_comb
    begin
        rs_val = (byp_reg.en && byp_reg.idx == rs) ? byp_reg.data : rf_a;
        rt_val = (byp_reg.en && byp_reg.idx == rt) ? byp_reg.data : rf_b;
        sum    = rs_val + imm;
        seq_pc = pc_reg + 32'd4;
        word   = sum[XLEN-1:2];
    end

    // Execute.
    always_comb
    begin
        next_pc_next = seq_pc;
        status_next  = STATUS_OK;
        rw_next      = 1'b0;
        ridx_next    = '0;
        rval_next    = '0;
        mw_next      = 1'b0;
        midx_next    = '0;
        mval_next    = '0;
        if (halted_reg)
        begin
            status_next = STATUS_HALTED;
        end
        else
        begin
            case (op)
                OP_ADDIU:
                begin
                    rw_next   = 1'b1;
                    ridx_next = rt;
                    rval_next = sum;
                end
                OP_SPECIAL:
                begin
                    if (funct == FUNCT_SUBU)
                    begin
                        rw_next   = 1'b1;
                        ridx_next = rd;
                        rval_next = rs_val - rt_val;
                    end
                end
                OP_SW:
                begin
                    if (word >= WORD_IDX_W'(DATA_WORDS))
                    begin
                        status_next = STATUS_BAD_ADDR;
                    end
                    else
                    begin
                        mw_next   = 1'b1;
                        midx_next = word[MEM_INDEX_W-1:0];
                        mval_next = rt_val;
                    end
                end
                OP_BNE:
                begin
                    if (rs_val != rt_val)
                    begin
                        next_pc_next = seq_pc + {imm[XLEN-3:0], 2'b00};
                    end
                end
                default:
                begin
                    status_next = STATUS_BAD_OP;
                end
            endcase
            // Register zero is hardwired; a write to it is dropped.
            if (rw_next && ridx_next == '0)
            begin
                rw_next   = 1'b0;
                rval_next = '0;
            end
        end
        // On an error or while halted the program counter stays put.
        if (status_next != STATUS_OK)
        begin
            next_pc_next = pc_reg;
        end
    end

    assign rf_wr.en   = ex_advance && rw_next;
    assign rf_wr.idx  = ridx_next;
    assign rf_wr.data = rval_next;

    // Architectural state, stage control and bypass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= START_RESET;
            pc_reg            <= START_RESET;
            halted_reg        <= 1'b0;
            ex_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            byp_reg           <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                start_address_reg <= pwdata;
                pc_reg            <= pwdata;
            end
            else if (ex_advance)
            begin
                pc_reg <= next_pc_next;
            end
            if (ex_advance && status_next != STATUS_OK)
            begin
                halted_reg <= 1'b1;
            end
            if (accept)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_advance)
            begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (rf_wr.en)
            begin
                byp_reg <= rf_wr;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_inst_reg <= inst_in.instruction;
        end
        if (ex_advance)
        begin
            next_pc_reg     <= next_pc_next;
            status_reg      <= status_next;
            reg_written_reg <= rw_next;
            reg_index_reg   <= ridx_next;
            reg_value_reg   <= rval_next;
            mem_written_reg <= mw_next;
            mem_index_reg   <= midx_next;
            mem_value_reg   <= mval_next;
        end
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.next_pc     = next_pc_reg;
    assign res_out.status      = status_reg;
    assign res_out.reg_written = reg_written_reg;
    assign res_out.reg_index   = reg_index_reg;
    assign res_out.reg_value   = reg_value_reg;
    assign res_out.mem_written = mem_written_reg;
    assign res_out.mem_index   = mem_index_reg;
    assign res_out.mem_value   = mem_value_reg;

`ifndef SYNTHESIS
    // Once halted, the block stays halted until reset.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared without reset");

    // Register zero is never written.
    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.en |-> (rf_wr.idx != '0))
        else $error("write to register zero");

    // A halted result carries no side effects.
    a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_HALTED)
        |-> (!reg_written_reg && !mem_written_reg))
        else $error("halted result reports a write");

    // An error leaves the program counter where it was.
    a_err_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_advance && status_next != STATUS_OK && !cfg_write)
        |=> (pc_reg == $past(pc_reg)))
        else $error("program counter moved on an error");

    // No item enters while the data memory is being cleared.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        dmem_busy |-> !accept)
        else $error("item taken during memory clear");
`endif

endmodule
